[rtl/core/plt_pkg.sv]
// Shared types and constants for the process lifecycle tracking table.
package plt_pkg;

  localparam int UID_W = 32;
  localparam int APP_W = 17;

  localparam logic [APP_W-1:0] UID_PER_USER = 17'd100000;
  localparam logic [UID_W-1:0] UID_NONE     = 32'hFFFF_FFFF;

  localparam logic [UID_W-1:0] MIN_APP_UID_RST    = 32'd10000;
  localparam logic [APP_W-1:0] ISOLATED_FIRST_RST = 17'd90000;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE         = 2'd0;
  localparam logic [1:0] CFG_MIN_APP_UID    = 2'd1;
  localparam logic [1:0] CFG_ISOLATED_FIRST = 2'd2;

  typedef enum logic [1:0] {
    FUNC_FORK  = 2'd0,
    FUNC_EXIT  = 2'd1,
    FUNC_UID   = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_INSERTED    = 3'd1,
    ACT_FULL        = 3'd2,
    ACT_EXITED      = 3'd3,
    ACT_SPECIALIZED = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[rtl/core/plt_uid_mod.sv]
// Remainder of a uid by the per-user uid span: reciprocal multiply plus one correction step.
module plt_uid_mod
  import plt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [UID_W-1:0] uid,
  output logic             busy,
  output logic [APP_W-1:0] rem
);

  // 100000 = 2^5 * 3125: drop 5 bits, then multiply by floor(2^40 / 3125).
  // The quotient estimate is exact or one low; one compare and subtract fixes it.
  localparam int SPAN_TZ  = 5;
  localparam int RECIP_SH = 40;
  localparam int RECIP_W  = 29;
  localparam int PROD_W   = UID_W - SPAN_TZ + RECIP_W;
  localparam int Q_W      = 16;
  localparam logic [RECIP_W-1:0] RECIP = 29'd351843720;

  logic              v1_r, v1_nxt;   // uid captured
  logic              v2_r, v2_nxt;   // quotient estimate ready
  logic              v3_r, v3_nxt;   // uncorrected remainder ready
  logic [UID_W-1:0]  uid_r, uid_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [APP_W:0]    diff_r, diff_nxt;
  logic [APP_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [UID_W-1:0]  qmul;
  logic [UID_W-1:0]  diff_full;
  logic [APP_W:0]    diff_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
    uid_r  <= uid_nxt;
    q_r    <= q_nxt;
    diff_r <= diff_nxt;
    rem_r  <= rem_nxt;
  end

  always_comb begin
    v1_nxt    = start;
    v2_nxt    = v1_r;
    v3_nxt    = v2_r;
    uid_nxt   = start ? uid : uid_r;
    prod      = uid_r[UID_W-1:SPAN_TZ] * RECIP;
    q_nxt     = prod[PROD_W-1:RECIP_SH];
    qmul      = {{(UID_W-Q_W){1'b0}}, q_r} * {{(UID_W-APP_W){1'b0}}, UID_PER_USER};
    // below 2 * 100000, so it fits in APP_W + 1 bits
    diff_full = uid_r - qmul;
    diff_nxt  = diff_full[APP_W:0];
    diff_sub  = diff_r - {1'b0, UID_PER_USER};
    if (diff_r >= {1'b0, UID_PER_USER}) begin
      rem_nxt = diff_sub[APP_W-1:0];
    end else begin
      rem_nxt = diff_r[APP_W-1:0];
    end
  end

  assign busy = v1_r | v2_r | v3_r;
  assign rem  = rem_r;

endmodule

[rtl/core/process_lifecycle_tracking_table.sv]
// Process lifecycle tracking table on one 1R1W slot memory, scanned linearly.
// Events are handled one at a time: in_tready is low from acceptance until the result is loaded,
//   and a result still waiting on out_tready holds the next event back.
// Pace is the scan (one slot read per cycle); the app id pipeline runs alongside it.
// Reset (rst_n low, synchronous) clears control and config, then a clearing pass over
//   every slot empties the table with in_tready low; config writes are taken at once.
module process_lifecycle_tracking_table
  import plt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int PID_BITS      = 22
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // input events
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // lsb up: pid, is_leader, zygote_parent, new_uid, zero fill
  input  logic [((PID_BITS + 2 + UID_W + 7) / 8) * 8 - 1:0] in_tdata,
  // func
  input  logic [1:0]                                in_tuser,
  // results
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // lsb up: out_pid, out_uid, app_id, zero fill
  output logic [((PID_BITS + UID_W + APP_W + 7) / 8) * 8 - 1:0] out_tdata,
  // action
  output logic [2:0]                                out_tuser,
  // configuration writes
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [1:0]                                cfg_index,
  input  logic [31:0]                               cfg_data
);

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int OUT_W = ((PID_BITS + UID_W + APP_W + 7) / 8) * 8;
  // memory word: {valid, specialized, uid, pid}
  localparam int W     = PID_BITS + UID_W + 2;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  logic             enable_r;
  logic [UID_W-1:0] min_app_uid_r;
  logic [APP_W-1:0] iso_first_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      min_app_uid_r <= MIN_APP_UID_RST;
      iso_first_r   <= ISOLATED_FIRST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:         enable_r      <= cfg_data[0];
        CFG_MIN_APP_UID:    min_app_uid_r <= cfg_data;
        CFG_ISOLATED_FIRST: iso_first_r   <= cfg_data[APP_W-1:0];
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: one read and one write port, registered read data.
  // ---------------------------------------------------------------------------
  logic [W-1:0]  mem [TABLE_ENTRIES];
  logic [W-1:0]  mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [W-1:0]  mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  logic                q_valid;
  logic                q_spec;
  logic [UID_W-1:0]    q_uid;
  logic [PID_BITS-1:0] q_pid;

  assign q_valid = mem_q_r[W-1];
  assign q_spec  = mem_q_r[W-2];
  assign q_uid   = mem_q_r[PID_BITS +: UID_W];
  assign q_pid   = mem_q_r[PID_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Remainder unit for app id, started with every accepted transaction.
  // ---------------------------------------------------------------------------
  logic             mod_start;
  logic             mod_busy;
  logic [APP_W-1:0] mod_rem;

  plt_uid_mod u_uid_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .uid   (in_tdata[PID_BITS+2 +: UID_W]),
    .busy  (mod_busy),
    .rem   (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // Control and scan state
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;          // sweep / read address
  logic                issue_r, issue_nxt;      // reads still to issue
  logic                chk_r, chk_nxt;          // mem_q_r holds a slot to check
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [UID_W-1:0]    hit_uid_r, hit_uid_nxt;
  logic                hit_spec_r, hit_spec_nxt;
  logic                free_r, free_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;

  // latched event
  func_t               func_r, func_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic                lead_r, lead_nxt;
  logic                zyg_r, zyg_nxt;
  logic [UID_W-1:0]    uid_r, uid_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  act_t                out_act_r, out_act_nxt;
  logic [PID_BITS-1:0] out_pid_r, out_pid_nxt;
  logic [UID_W-1:0]    out_uid_r, out_uid_nxt;
  logic [APP_W-1:0]    out_app_r, out_app_nxt;

  logic in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mod_start = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      chk_r       <= chk_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_uid_r  <= hit_uid_nxt;
    hit_spec_r <= hit_spec_nxt;
    free_idx_r <= free_idx_nxt;
    func_r     <= func_nxt;
    pid_r      <= pid_nxt;
    lead_r     <= lead_nxt;
    zyg_r      <= zyg_nxt;
    uid_r      <= uid_nxt;
    out_act_r  <= out_act_nxt;
    out_pid_r  <= out_pid_nxt;
    out_uid_r  <= out_uid_nxt;
    out_app_r  <= out_app_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    chk_nxt       = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_uid_nxt   = hit_uid_r;
    hit_spec_nxt  = hit_spec_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    func_nxt      = func_r;
    pid_nxt       = pid_r;
    lead_nxt      = lead_r;
    zyg_nxt       = zyg_r;
    uid_nxt       = uid_r;
    out_act_nxt   = out_act_r;
    out_pid_nxt   = out_pid_r;
    out_uid_nxt   = out_uid_r;
    out_app_nxt   = out_app_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = '0;
    mem_ra        = idx_r;

    // result register drains independently of the table work
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        // clearing pass, one slot per cycle
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = '0;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = func_t'(in_tuser);
          pid_nxt   = in_tdata[PID_BITS-1:0];
          lead_nxt  = in_tdata[PID_BITS];
          zyg_nxt   = in_tdata[PID_BITS+1];
          uid_nxt   = in_tdata[PID_BITS+2 +: UID_W];
          idx_nxt   = '0;
          issue_nxt = 1'b1;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = (func_t'(in_tuser) == FUNC_CLEAR) ? ST_CLEAR : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, check the slot read the cycle before
        mem_ra      = idx_r;
        chk_nxt     = issue_r;
        chk_idx_nxt = idx_r;
        if (issue_r) begin
          if (idx_r == LAST) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (chk_r) begin
          if (q_valid && (q_pid == pid_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = chk_idx_r;
            hit_uid_nxt  = q_uid;
            hit_spec_nxt = q_spec;
          end
          if (!q_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
        end
        if (!issue_r && !chk_r) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // decide, write back, and load the result once the slot is free
        if (!mod_busy && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = ACT_NONE;
          out_pid_nxt   = '0;
          out_uid_nxt   = '0;
          out_app_nxt   = '0;
          state_nxt     = ST_IDLE;
          case (func_r)
            FUNC_FORK: begin
              if (enable_r && lead_r && zyg_r && !hit_r) begin
                out_pid_nxt = pid_r;
                if (free_r) begin
                  out_act_nxt = ACT_INSERTED;
                  mem_we      = 1'b1;
                  mem_wa      = free_idx_r;
                  mem_wd      = {1'b1, 1'b0, UID_NONE, pid_r};
                end else begin
                  out_act_nxt = ACT_FULL;
                end
              end
            end
            FUNC_EXIT: begin
              if (enable_r && lead_r && hit_r) begin
                out_act_nxt = ACT_EXITED;
                out_pid_nxt = pid_r;
                out_uid_nxt = hit_uid_r;
                mem_we      = 1'b1;
                mem_wa      = hit_idx_r;
                mem_wd      = {1'b0, hit_spec_r, hit_uid_r, pid_r};
              end
            end
            FUNC_UID: begin
              if (enable_r && (uid_r >= min_app_uid_r) && (mod_rem < iso_first_r)
                  && hit_r && !hit_spec_r) begin
                out_act_nxt = ACT_SPECIALIZED;
                out_pid_nxt = pid_r;
                out_uid_nxt = uid_r;
                out_app_nxt = mod_rem;
                mem_we      = 1'b1;
                mem_wa      = hit_idx_r;
                mem_wd      = {1'b1, 1'b1, uid_r, pid_r};
              end
            end
            default: ;
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = OUT_W'({out_app_r, out_uid_r, out_pid_r});

endmodule

[rtl/core/plt_checker.sv]
// Port-level checker for the process lifecycle tracking table, with its bind.
module plt_port_checker
  import plt_pkg::*;
#(
  parameter int PID_BITS = 22
) (
  input logic                                               clk,
  input logic                                               rst_n,
  input logic                                               in_tready,
  input logic                                               out_tvalid,
  input logic                                               out_tready,
  input logic [((PID_BITS + UID_W + APP_W + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [2:0]                                         out_tuser
);

  logic [APP_W-1:0] app_f;
  logic [UID_W-1:0] uid_f;

  assign app_f = out_tdata[PID_BITS + UID_W +: APP_W];
  assign uid_f = out_tdata[PID_BITS +: UID_W];

  // the table is swept after reset before any event is taken
  a_init_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ACT_NONE || out_tuser == ACT_INSERTED ||
                    out_tuser == ACT_FULL || out_tuser == ACT_EXITED ||
                    out_tuser == ACT_SPECIALIZED))
    else $error("undefined action code");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_NONE |-> out_tdata == '0)
    else $error("no-action result carries data");

  a_app_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_SPECIALIZED |-> app_f == '0 &&
      (out_tuser == ACT_EXITED || uid_f == '0))
    else $error("app id or uid set for wrong action");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind process_lifecycle_tracking_table plt_port_checker #(.PID_BITS(PID_BITS)) u_plt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[sim/plt_checker.sv]
// Checker for the process lifecycle tracking table: mirrors the slot table and checks each result.
module plt_checker
  import plt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int PID_BITS      = 22
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_tvalid,
  input  logic                                               in_tready,
  input  logic [((PID_BITS + 2 + UID_W + 7) / 8) * 8 - 1:0]     in_tdata,
  input  logic [1:0]                                         in_tuser,
  input  logic                                               out_tvalid,
  input  logic                                               out_tready,
  input  logic [((PID_BITS + UID_W + APP_W + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic [2:0]                                         out_tuser,
  input  logic                                               cfg_valid,
  input  logic                                               cfg_ready,
  input  logic [1:0]                                         cfg_index,
  input  logic [31:0]                                        cfg_data,
  output int unsigned                                        fail_cnt,
  output int unsigned                                        awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    act_t                act;
    logic [PID_BITS-1:0] pid;
    logic [UID_W-1:0]    uid;
    logic [APP_W-1:0]    app;
  } track_result_t;

  // mirrored slot table and registers
  logic                slot_valid [TABLE_ENTRIES];
  logic [PID_BITS-1:0] slot_pid   [TABLE_ENTRIES];
  logic [UID_W-1:0]    slot_uid   [TABLE_ENTRIES];
  logic                slot_spec  [TABLE_ENTRIES];
  logic                en;
  logic [UID_W-1:0]    min_uid;
  logic [APP_W-1:0]    iso_first;

  track_result_t action_q[$];
  int unsigned   errors = 0;

  task automatic track_event(input func_t fn, input logic [PID_BITS-1:0] pid,
                             input logic leader, input logic zyg,
                             input logic [UID_W-1:0] uid);
    track_result_t res;
    int            hit;
    int            free_slot;
    logic [APP_W-1:0] app;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    // downward scan so the lowest matching / free slot wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_pid[i] == pid) hit = i;
      if (!slot_valid[i]) free_slot = i;
    end
    app = APP_W'(uid % UID_PER_USER);
    if (fn == FUNC_CLEAR) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
    end else if (en) begin
      case (fn)
        FUNC_FORK: begin
          if (leader && zyg && hit < 0) begin
            res.pid = pid;
            if (free_slot >= 0) begin
              slot_valid[free_slot] = 1'b1;
              slot_pid[free_slot]   = pid;
              slot_uid[free_slot]   = UID_NONE;
              slot_spec[free_slot]  = 1'b0;
              res.act = ACT_INSERTED;
            end else begin
              res.act = ACT_FULL;
            end
          end
        end
        FUNC_EXIT: begin
          if (leader && hit >= 0) begin
            res.act         = ACT_EXITED;
            res.pid         = pid;
            res.uid         = slot_uid[hit];
            slot_valid[hit] = 1'b0;
          end
        end
        FUNC_UID: begin
          if (uid >= min_uid && app < iso_first && hit >= 0 && !slot_spec[hit]) begin
            slot_uid[hit]  = uid;
            slot_spec[hit] = 1'b1;
            res.act        = ACT_SPECIALIZED;
            res.pid        = pid;
            res.uid        = uid;
            res.app        = app;
          end
        end
        default: ;
      endcase
    end
    action_q.push_back(res);
  endtask

  always @(posedge clk) begin : monitor
    track_result_t got;
    track_result_t want;
    if (!rst_n) begin
      en        = 1'b0;
      min_uid   = MIN_APP_UID_RST;
      iso_first = ISOLATED_FIRST_RST;
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
      action_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE:         en        = cfg_data[0];
          CFG_MIN_APP_UID:    min_uid   = cfg_data;
          CFG_ISOLATED_FIRST: iso_first = cfg_data[APP_W-1:0];
          default: ;
        endcase
      end
      // results are checked before this edge's input is predicted
      if (out_tvalid && out_tready) begin
        got.act = act_t'(out_tuser);
        got.pid = out_tdata[PID_BITS-1:0];
        got.uid = out_tdata[PID_BITS +: UID_W];
        got.app = out_tdata[PID_BITS + UID_W +: APP_W];
        if (action_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: action %0d pid %h uid %h app_id %0d",
                     got.act, got.pid, got.uid, got.app);
        end else begin
          want = action_q.pop_front();
          if (got.act !== want.act || got.pid !== want.pid ||
              got.uid !== want.uid || got.app !== want.app) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: action %0d/%0d pid %h/%h uid %h/%h app_id %0d/%0d (exp/got)",
                       want.act, got.act, want.pid, got.pid, want.uid, got.uid,
                       want.app, got.app);
          end
        end
      end
      if (in_tvalid && in_tready)
        track_event(func_t'(in_tuser), in_tdata[PID_BITS-1:0], in_tdata[PID_BITS],
                    in_tdata[PID_BITS+1], in_tdata[PID_BITS+2 +: UID_W]);
    end
    awaiting <= action_q.size();
    fail_cnt <= errors;
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the process lifecycle tracking table: stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import plt_pkg::*;

  localparam int TABLE_ENTRIES = 512;
  localparam int PID_BITS      = 22;
  localparam int IN_W          = ((PID_BITS + 2 + UID_W + 7) / 8) * 8;
  localparam int OUT_W         = ((PID_BITS + UID_W + APP_W + 7) / 8) * 8;
  localparam int MAX_WAIT      = 14;
  // a full scan plus margin, for the quiet stretch at the end
  localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 40;
  // register index with nothing behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [PID_BITS-1:0] PID_MAX = '1;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;   // lsb up: pid, is_leader, zygote_parent, new_uid
  logic [1:0]          in_tuser;   // func
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // lsb up: out_pid, out_uid, app_id, zero fill
  logic [2:0]          out_tuser;  // action
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_data;

  int unsigned         fail_cnt;
  int unsigned         awaiting;

  // stimulus-side copy of the registers, only used to shape uids
  logic [UID_W-1:0]    cur_min;
  logic [APP_W-1:0]    cur_iso;
  // when set, neither side inserts idle cycles
  bit                  no_idle;

  process_lifecycle_tracking_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PID_BITS      (PID_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  plt_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PID_BITS      (PID_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_cnt   (fail_cnt),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. A correct run needs roughly 13 ms (about 1100 events, each a full
  // table scan plus worst-case idle on both sides); this is several times that.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // One input transaction. Inputs move on the falling edge; the handshake is
  // sampled on the rising edge. tvalid stays high across back-to-back events.
  task automatic send_event(input func_t fn, input logic [PID_BITS-1:0] pid,
                            input bit leader, input bit zyg,
                            input logic [UID_W-1:0] uid);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {uid, zyg, leader, pid};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
  endtask

  // Drop tvalid and hold off until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Register write; callers make sure the block is idle first.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_APP_UID:    cur_min = data;
      CFG_ISOLATED_FIRST: cur_iso = data[APP_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly a small pool so events hit tracked entries; sometimes any pid.
  function automatic logic [PID_BITS-1:0] pick_pid();
    if ($urandom_range(0, 4) != 0) return PID_BITS'($urandom_range(0, 23));
    return PID_BITS'($urandom);
  endfunction

  // Distinct pids spread over the whole field, used to fill the table.
  function automatic logic [PID_BITS-1:0] fill_pid(input int k);
    return PID_BITS'(k * 8191 + 12345);
  endfunction

  // Uids that mostly pass the app / isolated test under the current settings,
  // plus the min_app_uid boundary and plain random values.
  function automatic logic [UID_W-1:0] pick_uid();
    longint unsigned v;
    int unsigned     sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      v = (cur_iso == 0) ? $urandom_range(0, 99999) : $urandom_range(0, cur_iso - 1);
      v += 64'd100000 * $urandom_range(cur_min / 100000, 42949);
      if (v <= 64'hFFFF_FFFF) return v[31:0];
    end else if (sel == 6) begin
      return cur_min - $urandom_range(0, 1);
    end
    return $urandom;
  endfunction

  // Result side: per transaction, either ready early (no stall) or hold ready
  // low, let the result sit, then release after a random stall.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        @(posedge clk);
        while (out_tvalid !== 1'b1) @(posedge clk);
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : stimulus
    int    n_items;
    int    r;
    func_t fn;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_FORK;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data  = '0;
    no_idle   = 1'b0;
    cur_min   = MIN_APP_UID_RST;
    cur_iso   = ISOLATED_FIRST_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // Still disabled out of reset: everything ignored, clear works anyway.
    send_event(FUNC_FORK,  22'd5, 1, 1, $urandom);
    send_event(FUNC_EXIT,  22'd5, 1, 1, $urandom);
    send_event(FUNC_UID,   22'd5, 1, 1, 32'd20000);
    send_event(FUNC_CLEAR, 22'd5, 1, 1, $urandom);
    wait_drained();
    cfg_write(CFG_ENABLE, 32'd1);
    cfg_write(CFG_MIN_APP_UID, MIN_APP_UID_RST);
    cfg_write(CFG_ISOLATED_FIRST, ISOLATED_FIRST_RST);

    send_event(FUNC_FORK, '0, 1, 1, $urandom);       // pid zero is a normal key
    send_event(FUNC_FORK, PID_MAX, 1, 1, $urandom);
    send_event(FUNC_FORK, '0, 1, 1, $urandom);       // already tracked
    send_event(FUNC_FORK, 22'd7, 0, 1, $urandom);    // not a group leader
    send_event(FUNC_FORK, 22'd7, 1, 0, $urandom);    // parent not zygote
    send_event(FUNC_UID, '0, 1, 0, 32'd10000);       // uid exactly min_app_uid
    send_event(FUNC_UID, '0, 1, 1, 32'd20001);       // already specialized
    send_event(FUNC_UID, PID_MAX, 1, 1, 32'd9999);   // below min_app_uid
    send_event(FUNC_UID, PID_MAX, 1, 1, 32'd1090000); // app id 90000, isolated
    send_event(FUNC_UID, 22'd7, 1, 1, 32'd20000);    // untracked pid
    send_event(FUNC_UID, PID_MAX, 0, 0, 32'hFFFF_FFFF); // leader bit ignored here
    send_event(FUNC_FORK, 22'd9, 1, 1, $urandom);
    send_event(FUNC_UID, 22'd9, 1, 1, 32'd1089999);  // last app id below isolated
    send_event(FUNC_EXIT, '0, 0, 1, $urandom);       // exit of a non-leader
    send_event(FUNC_EXIT, '0, 1, 0, $urandom);       // reports the specialized uid
    send_event(FUNC_EXIT, '0, 1, 1, $urandom);       // gone now
    send_event(FUNC_EXIT, PID_MAX, 1, 1, $urandom);
    send_event(FUNC_FORK, 22'd3, 1, 1, $urandom);
    send_event(FUNC_EXIT, 22'd3, 1, 1, $urandom);    // never specialized: all-ones uid
    send_event(FUNC_CLEAR, 22'd9, 0, 0, $urandom);   // clear while enabled
    send_event(FUNC_EXIT, 22'd9, 1, 1, $urandom);

    // --- random phases, one register setting each ---
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      n_items = 120;
      case (ph)
        1: begin
          cfg_write(CFG_MIN_APP_UID, 32'd0);
          cfg_write(CFG_ISOLATED_FIRST, 32'd99999);
        end
        2: begin
          // nothing can specialize; also poke the unused index
          cfg_write(CFG_MIN_APP_UID, 32'hFFFF_FFFF);
          cfg_write(CFG_ISOLATED_FIRST, 32'd0);
          cfg_write(CFG_SPARE, $urandom);
          n_items = 60;
        end
        3: begin
          cfg_write(CFG_MIN_APP_UID, $urandom_range(0, 1000000));
          cfg_write(CFG_ISOLATED_FIRST, $urandom_range(0, 99999));
        end
        4: begin
          cfg_write(CFG_ENABLE, 32'd0);
          n_items = 40;
        end
        5: begin
          cfg_write(CFG_ENABLE, 32'd1);
          cfg_write(CFG_MIN_APP_UID, $urandom);
          cfg_write(CFG_ISOLATED_FIRST, $urandom_range(0, 99999));
          n_items = 50;
        end
        6: begin
          cfg_write(CFG_MIN_APP_UID, 32'd10000);
          cfg_write(CFG_ISOLATED_FIRST, 32'd1);
          n_items = 50;
        end
        default: ;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
        // occasional full drain before the next event
        if ($urandom_range(0, 49) == 0) wait_drained();
        if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
        r  = $urandom_range(0, 99);
        fn = (r < 38) ? FUNC_FORK : (r < 62) ? FUNC_EXIT : (r < 96) ? FUNC_UID : FUNC_CLEAR;
        send_event(fn, pick_pid(), $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                   (fn == FUNC_UID) ? pick_uid() : $urandom);
      end
    end

    // --- fill the table to reach the full case ---
    wait_drained();
    cfg_write(CFG_MIN_APP_UID, MIN_APP_UID_RST);
    cfg_write(CFG_ISOLATED_FIRST, ISOLATED_FIRST_RST);
    send_event(FUNC_CLEAR, pick_pid(), 1, 1, $urandom);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k % 64 == 0) no_idle = ($urandom_range(0, 1) == 0);
      send_event(FUNC_FORK, fill_pid(k), 1, 1, $urandom);
    end
    for (int i = 0; i < 4; i++)
      send_event(FUNC_FORK, fill_pid(TABLE_ENTRIES + i), 1, 1, $urandom);  // no free slot
    send_event(FUNC_FORK, fill_pid(0), 1, 1, $urandom);  // tracked beats full
    // churn on the full table: freed slots get reused, then full again
    for (int i = 0; i < 16; i++) begin
      r = $urandom_range(0, 2);
      if (r == 0)
        send_event(FUNC_UID, fill_pid($urandom_range(0, TABLE_ENTRIES - 1)), 1, 1, pick_uid());
      else if (r == 1)
        send_event(FUNC_EXIT, fill_pid($urandom_range(0, TABLE_ENTRIES - 1)), 1, 1, $urandom);
      else
        send_event(FUNC_FORK, fill_pid(TABLE_ENTRIES + $urandom_range(0, 31)), 1, 1, $urandom);
    end
    send_event(FUNC_CLEAR, pick_pid(), 1, 1, $urandom);
    send_event(FUNC_EXIT, fill_pid(3), 1, 1, $urandom);

    // --- wrap up: drain, then a quiet stretch to catch stray results ---
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
